// ----- rtl/core/page_frame_buffer_engine_macros.svh -----
// ---------------------------------------------------------------------------
// page_frame_buffer_engine_macros.svh
// Assertion helpers shared by the frame buffer engine RTL.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_BUFFER_ENGINE_MACROS_SVH
`define PAGE_FRAME_BUFFER_ENGINE_MACROS_SVH

// same-cycle implication
`define PFBE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfbe: same-cycle check failed");

// next-cycle implication
`define PFBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfbe: next-cycle check failed");

`endif

// ----- rtl/core/pfbe_pkg.sv -----
// ---------------------------------------------------------------------------
// pfbe_pkg
// Shared types, opcodes and helpers of the page frame buffer engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfbe_pkg;

  localparam int COLUMNS_DEF = 64;
  localparam int ROWS_DEF    = 32;
  localparam int PAGE_ROWS   = 8;
  localparam int PAGE_SHIFT  = 3;

  localparam int OPCODE_W = 4;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 6;
  localparam int BIDX_W   = 8;
  localparam int BYTE_W   = 8;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET         = 4'd0,
    OP_CLEAR       = 4'd1,
    OP_INVERT      = 4'd2,
    OP_CLEAR_ALL   = 4'd3,
    OP_INVERT_ALL  = 4'd4,
    OP_MIRROR_Y    = 4'd5,
    OP_MIRROR_X    = 4'd6,
    OP_MIRROR_BOTH = 4'd7,
    OP_READ        = 4'd8
  } opcode_e;

  typedef enum logic [1:0] {
    WALK_Y    = 2'd0,
    WALK_X    = 2'd1,
    WALK_BOTH = 2'd2
  } walk_mode_e;

  typedef struct packed {
    logic       start;
    logic       step;
    walk_mode_e mode;
  } walk_ctrl_t;

  function automatic logic [BYTE_W-1:0] flip_bits(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int k = 0; k < BYTE_W; k++) begin
      r[k] = v[BYTE_W-1-k];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/page_frame_buffer_engine.sv -----
// ---------------------------------------------------------------------------
// page_frame_buffer_engine
// Monochrome page-organized frame store with pixel, whole-store, mirror
// and byte-read commands; one status word per command.
// Pixel commands read, then modify-write one byte; refused ones write nothing.
// Byte read: RAM read data is registered, then loaded into the output word;
// others load at accept. Clear all zeroes each byte; invert all reads and writes
// back each byte; mirrors read a byte pair, then write both through the single
// RAM write port. Reset clears the store (256 by default), s_axis_tready low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_frame_buffer_engine_macros.svh"

module page_frame_buffer_engine import pfbe_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // opcode[3:0], pixel_column[10:4], pixel_row[16:11], byte_index[24:17]
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[0], read_byte[8:1]
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  localparam int PAGES       = ROWS / PAGE_ROWS;
  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);

  typedef enum logic [8:0] {
    S_INIT    = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_PIX     = 9'b000000100,
    S_READ    = 9'b000001000,
    S_INV_RD  = 9'b000010000,
    S_INV_WR  = 9'b000100000,
    S_MIR_RD  = 9'b001000000,
    S_MIR_WR1 = 9'b010000000,
    S_MIR_WR2 = 9'b100000000
  } state_t;

  state_t state, state_next;

  opcode_e           in_op;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [BIDX_W-1:0] in_bidx;
  logic              pix_ok, rd_ok, accept;
  logic [AW-1:0]     pix_idx, rd_idx;
  logic [BYTE_W-1:0] pix_mask_in;

  logic [AW-1:0]     sweep, sweep_next;
  logic [AW-1:0]     pix_addr;
  logic [BYTE_W-1:0] pix_mask;
  opcode_e           pix_op;
  logic [BYTE_W-1:0] hold;
  logic              flip;

  logic              out_valid, out_status;
  logic [BYTE_W-1:0] out_byte;
  logic              load, load_status;
  logic [BYTE_W-1:0] load_byte;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [BYTE_W-1:0] ram_wdata, rd_a, rd_b;

  walk_ctrl_t        walk_ctrl;
  logic [AW-1:0]     walk_i, walk_j;
  logic              walk_last;

  assign in_op   = opcode_e'(s_axis_tdata[OPCODE_W-1:0]);
  assign in_col  = s_axis_tdata[OPCODE_W +: COL_W];
  assign in_row  = s_axis_tdata[OPCODE_W+COL_W +: ROW_W];
  assign in_bidx = s_axis_tdata[OPCODE_W+COL_W+ROW_W +: BIDX_W];

  assign pix_ok      = (int'(in_col) < COLUMNS) && (int'(in_row) < ROWS);
  assign rd_ok       = int'(in_bidx) < STORE_BYTES;
  assign pix_idx     = AW'(int'(in_col) + int'(in_row >> PAGE_SHIFT) * COLUMNS);
  assign rd_idx      = AW'(in_bidx);
  assign pix_mask_in = BYTE_W'(1) << in_row[PAGE_SHIFT-1:0];

  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_DATA_W-BYTE_W-1){1'b0}}, out_byte, out_status};

  pfbe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  pfbe_walk #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_walk (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (walk_ctrl),
    .addr_i (walk_i),
    .addr_j (walk_j),
    .last   (walk_last)
  );

  always_comb begin
    state_next  = state;
    sweep_next  = sweep;
    walk_ctrl   = '{start: 1'b0, step: 1'b0, mode: WALK_Y};
    ram_we      = 1'b0;
    ram_waddr   = sweep;
    ram_wdata   = '0;
    ram_raddr_a = sweep;
    ram_raddr_b = walk_j;
    load        = 1'b0;
    load_status = 1'b0;
    load_byte   = '0;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
        if (sweep == AW'(STORE_BYTES - 1)) begin
          sweep_next = '0;
          state_next = S_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      S_IDLE: begin
        ram_raddr_a = (in_op == OP_READ) ? rd_idx : pix_idx;
        if (accept) begin
          unique case (in_op)
            OP_SET, OP_CLEAR, OP_INVERT: begin
              load        = 1'b1;
              load_status = !pix_ok;
              if (pix_ok) begin
                state_next = S_PIX;
              end
            end
            OP_CLEAR_ALL: begin
              load       = 1'b1;
              state_next = S_INIT;
            end
            OP_INVERT_ALL: begin
              load       = 1'b1;
              state_next = S_INV_RD;
            end
            OP_MIRROR_Y: begin
              load            = 1'b1;
              walk_ctrl.start = 1'b1;
              walk_ctrl.mode  = WALK_Y;
              state_next      = S_MIR_RD;
            end
            OP_MIRROR_X: begin
              load            = 1'b1;
              walk_ctrl.start = 1'b1;
              walk_ctrl.mode  = WALK_X;
              state_next      = S_MIR_RD;
            end
            OP_MIRROR_BOTH: begin
              load            = 1'b1;
              walk_ctrl.start = 1'b1;
              walk_ctrl.mode  = WALK_BOTH;
              state_next      = S_MIR_RD;
            end
            OP_READ: begin
              if (rd_ok) begin
                state_next = S_READ;
              end else begin
                load        = 1'b1;
                load_status = 1'b1;
              end
            end
            default: begin
              load        = 1'b1;
              load_status = 1'b1;
            end
          endcase
        end
      end
      S_PIX: begin
        ram_we    = 1'b1;
        ram_waddr = pix_addr;
        unique case (pix_op)
          OP_SET:   ram_wdata = rd_a | pix_mask;
          OP_CLEAR: ram_wdata = rd_a & ~pix_mask;
          default:  ram_wdata = rd_a ^ pix_mask;
        endcase
        state_next = S_IDLE;
      end
      S_READ: begin
        load       = 1'b1;
        load_byte  = rd_a;
        state_next = S_IDLE;
      end
      S_INV_RD: begin
        state_next = S_INV_WR;
      end
      S_INV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
        ram_wdata = ~rd_a;
        if (sweep == AW'(STORE_BYTES - 1)) begin
          sweep_next = '0;
          state_next = S_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
          state_next = S_INV_RD;
        end
      end
      S_MIR_RD: begin
        ram_raddr_a = walk_i;
        ram_raddr_b = walk_j;
        state_next  = S_MIR_WR1;
      end
      S_MIR_WR1: begin
        ram_we     = 1'b1;
        ram_waddr  = walk_i;
        ram_wdata  = flip ? flip_bits(rd_b) : rd_b;
        state_next = S_MIR_WR2;
      end
      S_MIR_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = walk_j;
        ram_wdata = flip ? flip_bits(hold) : hold;
        if (walk_last) begin
          state_next = S_IDLE;
        end else begin
          walk_ctrl.step = 1'b1;
          state_next     = S_MIR_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_addr <= pix_idx;
      pix_mask <= pix_mask_in;
      pix_op   <= in_op;
      flip     <= (in_op == OP_MIRROR_X) || (in_op == OP_MIRROR_BOTH);
    end
    if (state == S_MIR_WR1) begin
      hold <= rd_a;
    end
    if (load) begin
      out_status <= load_status;
      out_byte   <= load_byte;
    end
  end

  `PFBE_ASSERT_NEXT(a_read_slot_free, clk, rst, accept && (in_op == OP_READ) && rd_ok, !m_axis_tvalid)
  `PFBE_ASSERT_IMP(a_idle_no_write, clk, rst, state == S_IDLE, !ram_we)
  `PFBE_ASSERT_NEXT(a_clear_pass_ends, clk, rst, (state == S_INIT) && (sweep == AW'(STORE_BYTES - 1)), state == S_IDLE)
  `PFBE_ASSERT_NEXT(a_mirror_ends, clk, rst, (state == S_MIR_WR2) && walk_last, state == S_IDLE)

endmodule

// ----- rtl/core/pfbe_ram.sv -----
// ---------------------------------------------------------------------------
// pfbe_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfbe_ram #(
  parameter int   WIDTH = 8,
  parameter int   DEPTH = 256,
  localparam int  AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/pfbe_walk.sv -----
// ---------------------------------------------------------------------------
// pfbe_walk
// Pair address generator for the mirror sweeps: yields each pair (i, j)
// of bytes that trade places once, with i never above j.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_frame_buffer_engine_macros.svh"

module pfbe_walk import pfbe_pkg::*; #(
  parameter int  COLUMNS     = COLUMNS_DEF,
  parameter int  ROWS        = ROWS_DEF,
  localparam int PAGES       = ROWS / PAGE_ROWS,
  localparam int STORE_BYTES = COLUMNS * PAGES,
  localparam int AW          = $clog2(STORE_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  walk_ctrl_t    ctrl,
  output logic [AW-1:0] addr_i,
  output logic [AW-1:0] addr_j,
  output logic          last
);

  localparam int CW      = $clog2(COLUMNS);
  localparam int PW      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int YC_LAST = (COLUMNS - 1) / 2;
  localparam int XP_LAST = (PAGES - 1) / 2;
  localparam int B_LAST  = (STORE_BYTES - 1) / 2;

  logic [CW-1:0] col_cnt;
  logic [PW-1:0] page_cnt;
  walk_mode_e    mode;

  always_comb begin
    unique case (mode)
      WALK_Y:    last = (page_cnt == PW'(PAGES - 1)) && (col_cnt == CW'(YC_LAST));
      WALK_X:    last = (page_cnt == PW'(XP_LAST)) && (col_cnt == CW'(COLUMNS - 1));
      WALK_BOTH: last = (addr_i == AW'(B_LAST));
      default:   last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_i   <= '0;
      addr_j   <= '0;
      col_cnt  <= '0;
      page_cnt <= '0;
      mode     <= WALK_Y;
    end else if (ctrl.start) begin
      mode     <= ctrl.mode;
      addr_i   <= '0;
      col_cnt  <= '0;
      page_cnt <= '0;
      unique case (ctrl.mode)
        WALK_Y:  addr_j <= AW'(COLUMNS - 1);
        WALK_X:  addr_j <= AW'((PAGES - 1) * COLUMNS);
        default: addr_j <= AW'(STORE_BYTES - 1);
      endcase
    end else if (ctrl.step) begin
      unique case (mode)
        WALK_Y: begin
          if (col_cnt == CW'(YC_LAST)) begin
            page_cnt <= page_cnt + 1'b1;
            col_cnt  <= '0;
            addr_i   <= addr_i + AW'(COLUMNS - YC_LAST);
            addr_j   <= addr_i + AW'(2 * COLUMNS - 1 - YC_LAST);
          end else begin
            col_cnt <= col_cnt + 1'b1;
            addr_i  <= addr_i + 1'b1;
            addr_j  <= addr_j - 1'b1;
          end
        end
        WALK_X: begin
          addr_i <= addr_i + 1'b1;
          if (col_cnt == CW'(COLUMNS - 1)) begin
            page_cnt <= page_cnt + 1'b1;
            col_cnt  <= '0;
            addr_j   <= addr_j - AW'(2 * COLUMNS - 1);
          end else begin
            col_cnt <= col_cnt + 1'b1;
            addr_j  <= addr_j + 1'b1;
          end
        end
        default: begin
          addr_i <= addr_i + 1'b1;
          addr_j <= addr_j - 1'b1;
        end
      endcase
    end
  end

  `PFBE_ASSERT_IMP(a_pair_order, clk, rst, 1'b1, addr_i <= addr_j)

endmodule

// ----- tb/page_frame_buffer_engine_tb.sv -----
// ---------------------------------------------------------------------------
// page_frame_buffer_engine_tb
// Self-checking bench for the page frame buffer engine. A queue of commands
// (directed corner cases, then weighted random traffic) feeds a stream
// driver. Each accepted command runs through a local model of the frame store
// to get the expected status word, which the monitor compares field by field
// against every word on m_axis. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_buffer_engine_tb;
  import pfbe_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int ROWS_N      = ROWS_DEF;
  localparam int PAGES       = ROWS_N / PAGE_ROWS;
  localparam int STORE_BYTES = COLS * PAGES;
  localparam int RANDOM_CMDS = 730;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 600;

  localparam logic [OPCODE_W-1:0] OP_FIRST_BAD = 4'd9;
  localparam logic [OPCODE_W-1:0] OP_LAST_BAD  = 4'd15;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [BIDX_W-1:0]   bidx;
    int unsigned         gap;
    bit                  drain;
  } pfb_cmd_t;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] rd;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  pfb_cmd_t    cmd_queue[$];
  reply_t      expected_replies[$];
  logic [7:0]  frame_model [STORE_BYTES];
  pfb_cmd_t    cur_cmd;
  int unsigned gap_left = 0;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned recv_calm = 0;
  int unsigned idle_cycles = 0;
  int          err_count = 0;

  page_frame_buffer_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[7-k] = v[k];
    return r;
  endfunction

  // expected reply of one command; updates the model store
  function automatic reply_t frame_model_apply(input pfb_cmd_t c);
    reply_t     r;
    logic [7:0] snap [STORE_BYTES];
    int         idx;
    r.status = 1'b0;
    r.rd     = '0;
    case (c.op)
      OP_SET, OP_CLEAR, OP_INVERT: begin
        if (c.col >= COLS || c.row >= ROWS_N) begin
          r.status = 1'b1;
        end else begin
          idx = int'(c.col) + int'(c.row >> PAGE_SHIFT) * COLS;
          case (c.op)
            OP_SET:   frame_model[idx][c.row[2:0]] = 1'b1;
            OP_CLEAR: frame_model[idx][c.row[2:0]] = 1'b0;
            default:  frame_model[idx][c.row[2:0]] = ~frame_model[idx][c.row[2:0]];
          endcase
        end
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < STORE_BYTES; i++) frame_model[i] = '0;
      end
      OP_INVERT_ALL: begin
        for (int i = 0; i < STORE_BYTES; i++) frame_model[i] = ~frame_model[i];
      end
      OP_MIRROR_Y, OP_MIRROR_X, OP_MIRROR_BOTH: begin
        snap = frame_model;
        for (int p = 0; p < PAGES; p++) begin
          for (int cc = 0; cc < COLS; cc++) begin
            idx = p * COLS + cc;
            case (c.op)
              OP_MIRROR_Y: frame_model[idx] = snap[p * COLS + (COLS - 1 - cc)];
              OP_MIRROR_X: frame_model[idx] = rev8(snap[(PAGES - 1 - p) * COLS + cc]);
              default:     frame_model[idx] = rev8(snap[STORE_BYTES - 1 - idx]);
            endcase
          end
        end
      end
      OP_READ: begin
        if (c.bidx < STORE_BYTES) r.rd = frame_model[c.bidx];
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  task automatic add_cmd(input logic [OPCODE_W-1:0] op, input int col, input int row,
                         input int bidx, input bit drain);
    pfb_cmd_t    c;
    int unsigned roll;
    c.op    = op;
    c.col   = col[COL_W-1:0];
    c.row   = row[ROW_W-1:0];
    c.bidx  = bidx[BIDX_W-1:0];
    c.drain = drain;
    roll    = $urandom_range(0, 99);
    if (send_calm != 0) begin
      send_calm--;
      c.gap = 0;
    end else if (roll < 3) begin
      send_calm = $urandom_range(15, 50);
      c.gap = 0;
    end else if (roll < 60) begin
      c.gap = 0;
    end else if (roll < 92) begin
      c.gap = $urandom_range(1, 3);
    end else begin
      c.gap = $urandom_range(8, 40);
    end
    cmd_queue.push_back(c);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: %0t %s mismatch, got 0x%0h expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // stimulus and end of run
  initial begin
    int unsigned roll;
    int          last_idx;
    int          col;
    int          row;
    for (int i = 0; i < STORE_BYTES; i++) frame_model[i] = '0;

    add_cmd(OP_READ, 127, 63, 0, 1'b0);
    add_cmd(OP_SET, 0, 0, 255, 1'b0);
    add_cmd(OP_SET, 63, 31, 0, 1'b0);
    add_cmd(OP_READ, 0, 0, 0, 1'b0);
    add_cmd(OP_READ, 0, 0, 255, 1'b0);
    add_cmd(OP_INVERT, 63, 31, 170, 1'b0);
    add_cmd(OP_READ, 85, 42, 255, 1'b0);
    add_cmd(OP_CLEAR, 0, 0, 85, 1'b0);
    add_cmd(OP_SET, 64, 0, 0, 1'b0);
    add_cmd(OP_SET, 127, 63, 0, 1'b0);
    add_cmd(OP_CLEAR, 0, 32, 0, 1'b0);
    add_cmd(OP_INVERT, 10, 63, 0, 1'b0);
    add_cmd(OP_FIRST_BAD, 5, 5, 5, 1'b0);
    add_cmd(OP_LAST_BAD, 127, 63, 255, 1'b0);
    add_cmd(OP_SET, 1, 1, 0, 1'b0);
    add_cmd(OP_SET, 2, 17, 0, 1'b0);
    add_cmd(OP_MIRROR_Y, 0, 0, 0, 1'b0);
    add_cmd(OP_READ, 0, 0, 62, 1'b0);
    add_cmd(OP_MIRROR_X, 0, 0, 0, 1'b0);
    add_cmd(OP_READ, 0, 0, 190, 1'b0);
    add_cmd(OP_MIRROR_BOTH, 0, 0, 0, 1'b0);
    add_cmd(OP_INVERT_ALL, 0, 0, 0, 1'b0);
    add_cmd(OP_READ, 0, 0, 170, 1'b0);
    add_cmd(OP_CLEAR_ALL, 0, 0, 0, 1'b1);
    add_cmd(OP_READ, 0, 0, 255, 1'b0);

    last_idx = 0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      roll = $urandom_range(0, 99);
      col  = $urandom_range(0, 127);
      row  = $urandom_range(0, 63);
      if (roll < 36) begin
        col      = $urandom_range(0, COLS - 1);
        row      = $urandom_range(0, ROWS_N - 1);
        last_idx = col + (row >> PAGE_SHIFT) * COLS;
        add_cmd(OPCODE_W'(OP_SET + $urandom_range(0, 2)), col, row, $urandom_range(0, 255),
                $urandom_range(0, 39) == 0);
      end else if (roll < 42) begin
        case ($urandom_range(0, 2))
          0:       col = $urandom_range(COLS, 127);
          1:       row = $urandom_range(ROWS_N, 63);
          default: begin
            col = $urandom_range(COLS, 127);
            row = $urandom_range(ROWS_N, 63);
          end
        endcase
        add_cmd(OPCODE_W'(OP_SET + $urandom_range(0, 2)), col, row, $urandom_range(0, 255),
                1'b0);
      end else if (roll < 80) begin
        add_cmd(OP_READ, col, row, $urandom_range(0, 1) ? last_idx : $urandom_range(0, 255),
                $urandom_range(0, 39) == 0);
      end else if (roll < 83) begin
        add_cmd(OP_CLEAR_ALL, col, row, $urandom_range(0, 255), 1'b0);
      end else if (roll < 88) begin
        add_cmd(OP_INVERT_ALL, col, row, $urandom_range(0, 255), 1'b0);
      end else if (roll < 91) begin
        add_cmd(OP_MIRROR_Y, col, row, $urandom_range(0, 255), 1'b0);
      end else if (roll < 94) begin
        add_cmd(OP_MIRROR_X, col, row, $urandom_range(0, 255), 1'b0);
      end else if (roll < 97) begin
        add_cmd(OP_MIRROR_BOTH, col, row, $urandom_range(0, 255), 1'b0);
      end else begin
        add_cmd(OPCODE_W'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD)), col, row,
                $urandom_range(0, 255), 1'b0);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // driver: a drain command waits until every reply is back
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(frame_model_apply(cur_cmd));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain && expected_replies.size() != 0)) begin
          cur_cmd       <= cmd_queue[0];
          s_axis_tdata  <= {7'b0, cmd_queue[0].bidx, cmd_queue[0].row, cmd_queue[0].col,
                            cmd_queue[0].op};
          gap_left      <= cmd_queue[0].gap;
          s_axis_tvalid <= 1'b1;
          cmd_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compare each word with the oldest expectation
  always @(posedge clk) begin
    reply_t      want;
    int unsigned roll;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 0);
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tdata[0] !== want.status)
            report_mismatch("status", m_axis_tdata[0], want.status);
          if (m_axis_tdata[8:1] !== want.rd)
            report_mismatch("read_byte", m_axis_tdata[8:1], want.rd);
        end
      end
      roll = $urandom_range(0, 99);
      if (recv_calm != 0) begin
        recv_calm     <= recv_calm - 1;
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (roll < 3) recv_calm <= $urandom_range(20, 60);
        else if (roll < 65) stall_left <= 0;
        else if (roll < 92) stall_left <= $urandom_range(1, 3);
        else stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pfbe_pkg.sv
rtl/core/pfbe_ram.sv
rtl/core/pfbe_walk.sv
rtl/core/page_frame_buffer_engine.sv
tb/page_frame_buffer_engine_tb.sv
